@@ rtl/core/riscv_decode_execute_assert.svh @@
// Assertion macros for the decode/execute block.
// Used by riscv_decode_execute; needs no other file.
`ifndef RISCV_DECODE_EXECUTE_ASSERT_SVH
`define RISCV_DECODE_EXECUTE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rde: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rde: next-cycle check failed");

`endif

@@ rtl/core/rde_pkg.sv @@
// Shared constants and types of the decode/execute block.
// No dependencies.
package rde_pkg;

    localparam int XLEN = 32;

    localparam logic [6:0] OPC_REG    = 7'b0110011;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MULD = 7'b0000001;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;   // add, sub, addi
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;   // srl, sra
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_SIZE_MAX = 3'd2;   // widest load/store: word

    localparam logic [XLEN-1:0] SIGN_BIT = 32'h8000_0000;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
    localparam logic [1:0] STATUS_DIVZERO = 2'd2;
    localparam logic [1:0] STATUS_HALT    = 2'd3;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;

    // one divider stage per quotient bit
    localparam int DIV_STAGES = XLEN;

    typedef struct packed {
        logic [4:0]      dest_index;
        logic            write_enable;
        logic [XLEN-1:0] write_data;
        logic [1:0]      mem_kind;
        logic [1:0]      mem_size;
        logic [XLEN-1:0] mem_address;
        logic [XLEN-1:0] store_value;
        logic [XLEN-1:0] next_pc;
        logic            pc_redirect;
        logic [1:0]      status;
    } t_res;

    typedef struct packed {
        logic            valid;
        t_res            res;
        logic            is_div;
        logic            want_rem;
        logic            neg_q;
        logic            neg_r;
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] divisor;
    } t_div;

endpackage

@@ rtl/core/rde_if.sv @@
// Word channels of the decode/execute block: instruction in, result out.
// Depends on rde_pkg.
interface rde_in_if;
    logic                    valid;
    logic                    ready;
    logic [rde_pkg::XLEN-1:0] instr_word;
    logic [rde_pkg::XLEN-1:0] pc_value;
    logic [rde_pkg::XLEN-1:0] src1_value;
    logic [rde_pkg::XLEN-1:0] src2_value;
    modport source (output valid, instr_word, pc_value, src1_value, src2_value, input ready);
    modport sink (input valid, instr_word, pc_value, src1_value, src2_value, output ready);
endinterface

interface rde_out_if;
    logic                    valid;
    logic                    ready;
    logic [4:0]              dest_index;
    logic                    write_enable;
    logic [rde_pkg::XLEN-1:0] write_data;
    logic [1:0]              mem_kind;
    logic [1:0]              mem_size;
    logic [rde_pkg::XLEN-1:0] mem_address;
    logic [rde_pkg::XLEN-1:0] store_value;
    logic [rde_pkg::XLEN-1:0] next_pc;
    logic                    pc_redirect;
    logic [1:0]              status;
    modport source (output valid, dest_index, write_enable, write_data, mem_kind, mem_size,
                    mem_address, store_value, next_pc, pc_redirect, status, input ready);
    modport sink (input valid, dest_index, write_enable, write_data, mem_kind, mem_size,
                  mem_address, store_value, next_pc, pc_redirect, status, output ready);
endinterface

@@ rtl/core/riscv_decode_execute.sv @@
// RV32IM subset decode and execute unit, fully pipelined.
// Depends on rde_pkg, rde_if.sv and riscv_decode_execute_assert.svh.
// Pipeline: input register, decode/ALU/multiply stage, 32 restoring-divider stages one quotient
// bit each, output register.
// Throughput: one word per cycle; the whole pipe advances together and holds on output stall.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; payload is not reset.
module riscv_decode_execute (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rde_in_if.sink    i_in,
    rde_out_if.source o_out
);
    `include "riscv_decode_execute_assert.svh"

    localparam int W = rde_pkg::XLEN;
    localparam int DIV_STAGES_P1 = rde_pkg::DIV_STAGES + 1;

    // Global advance: the pipe moves when the output slot is empty or being taken.
    logic w_adv;
    assign w_adv    = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // ---------------- stage A: input register ----------------
    logic         r_a_valid;
    logic [W-1:0] r_a_instr, r_a_pc, r_a_src1, r_a_src2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_in.valid;
        end
        if (w_adv) begin
            r_a_instr <= i_in.instr_word;
            r_a_pc    <= i_in.pc_value;
            r_a_src1  <= i_in.src1_value;
            r_a_src2  <= i_in.src2_value;
        end
    end

    // ---------------- stage B: decode, ALU, multiply ----------------
    // Produces the final result for every instruction but div/rem, whose data
    // is filled in after the divider stages.
    rde_pkg::t_div n_div [DIV_STAGES_P1-1:0];
    rde_pkg::t_div r_div [DIV_STAGES_P1-1:0];

    always_comb begin
        logic [6:0]   opc, f7;
        logic [4:0]   rd, sh;
        logic [2:0]   f3;
        logic [W-1:0] a, b, pc, pc4, imm_i, imm_s, imm_b, imm_j, data, npc, addr, sdata;
        logic [1:0]   kind, size, status;
        logic         writes, illegal, taken, cond, lt, is_div, we;

        a     = r_a_src1;
        b     = r_a_src2;
        pc    = r_a_pc;
        pc4   = pc + W'(4);
        opc   = r_a_instr[6:0];
        rd    = r_a_instr[11:7];
        f3    = r_a_instr[14:12];
        f7    = r_a_instr[31:25];
        sh    = b[4:0];
        imm_i = {{20{r_a_instr[31]}}, r_a_instr[31:20]};
        imm_s = {{20{r_a_instr[31]}}, r_a_instr[31:25], r_a_instr[11:7]};
        imm_b = {{19{r_a_instr[31]}}, r_a_instr[31], r_a_instr[7], r_a_instr[30:25],
                 r_a_instr[11:8], 1'b0};
        imm_j = {{11{r_a_instr[31]}}, r_a_instr[31], r_a_instr[19:12], r_a_instr[20],
                 r_a_instr[30:21], 1'b0};
        lt    = $signed(a) < $signed(b);
        data  = '0;
        npc   = pc4;
        addr  = '0;
        sdata = '0;
        kind  = rde_pkg::MEM_NONE;
        size  = rde_pkg::SIZE_BYTE;
        status = rde_pkg::STATUS_OK;
        writes = 1'b0;
        illegal = 1'b0;
        taken  = 1'b0;
        cond   = 1'b0;
        is_div = 1'b0;

        if (r_a_instr == '0) begin
            status = rde_pkg::STATUS_HALT;
            npc    = pc;
        end else begin
            case (opc)
                rde_pkg::OPC_REG: begin
                    writes = 1'b1;
                    if (f7 == rde_pkg::F7_BASE) begin
                        case (f3)
                            rde_pkg::F3_ADD: data = a + b;
                            rde_pkg::F3_SLL: data = a << sh;
                            rde_pkg::F3_SLT: data = {{(W-1){1'b0}}, lt};
                            rde_pkg::F3_XOR: data = a ^ b;
                            rde_pkg::F3_SR:  data = a >> sh;
                            rde_pkg::F3_OR:  data = a | b;
                            rde_pkg::F3_AND: data = a & b;
                            default: illegal = 1'b1;
                        endcase
                    end else if (f7 == rde_pkg::F7_ALT) begin
                        if (f3 == rde_pkg::F3_ADD) data = a - b;
                        else if (f3 == rde_pkg::F3_SR) data = W'($signed(a) >>> sh);
                        else illegal = 1'b1;
                    end else if (f7 == rde_pkg::F7_MULD) begin
                        if (f3 == rde_pkg::F3_MUL) data = a * b;
                        else if (f3 == rde_pkg::F3_DIV || f3 == rde_pkg::F3_REM) begin
                            is_div = 1'b1;
                            if (b == '0) status = rde_pkg::STATUS_DIVZERO;
                        end else illegal = 1'b1;
                    end else begin
                        illegal = 1'b1;
                    end
                end
                rde_pkg::OPC_IMM: begin
                    writes = 1'b1;
                    case (f3)
                        rde_pkg::F3_ADD: data = a + imm_i;
                        rde_pkg::F3_OR:  data = a | imm_i;
                        rde_pkg::F3_AND: data = a & imm_i;
                        default: illegal = 1'b1;
                    endcase
                end
                rde_pkg::OPC_LOAD: begin
                    writes = 1'b1;
                    if (f3 <= rde_pkg::F3_SIZE_MAX) begin
                        kind = rde_pkg::MEM_LOAD;
                        size = f3[1:0];
                        addr = a + imm_i;
                    end else illegal = 1'b1;
                end
                rde_pkg::OPC_JALR: begin
                    writes = 1'b1;
                    if (f3 == rde_pkg::F3_JALR) begin
                        data  = pc4;
                        npc   = (a + imm_i) & ~W'(1);
                        taken = 1'b1;
                    end else illegal = 1'b1;
                end
                rde_pkg::OPC_STORE: begin
                    if (f3 <= rde_pkg::F3_SIZE_MAX) begin
                        kind  = rde_pkg::MEM_STORE;
                        size  = f3[1:0];
                        addr  = a + imm_s;
                        sdata = b;
                    end else illegal = 1'b1;
                end
                rde_pkg::OPC_BRANCH: begin
                    case (f3)
                        rde_pkg::F3_BEQ: cond = (a == b);
                        rde_pkg::F3_BNE: cond = (a != b);
                        rde_pkg::F3_BLT: cond = lt;
                        rde_pkg::F3_BGE: cond = !lt;
                        default: illegal = 1'b1;
                    endcase
                    if (cond) begin
                        npc   = pc + imm_b;
                        taken = 1'b1;
                    end
                end
                rde_pkg::OPC_AUIPC: begin
                    writes = 1'b1;
                    data   = pc + {r_a_instr[31:12], 12'd0};
                end
                rde_pkg::OPC_LUI: begin
                    writes = 1'b1;
                    data   = {r_a_instr[31:12], 12'd0};
                end
                rde_pkg::OPC_JAL: begin
                    writes = 1'b1;
                    data   = pc4;
                    npc    = pc + imm_j;
                    taken  = 1'b1;
                end
                default: illegal = 1'b1;
            endcase
        end

        if (illegal) begin
            writes = 1'b0;
            kind   = rde_pkg::MEM_NONE;
            size   = rde_pkg::SIZE_BYTE;
            addr   = '0;
            sdata  = '0;
            npc    = pc;
            taken  = 1'b0;
            status = rde_pkg::STATUS_ILLEGAL;
            is_div = 1'b0;
        end
        we = writes && (rd != 5'd0) && (status == rde_pkg::STATUS_OK);
        // loads get their data from the memory stage
        if (!we || kind == rde_pkg::MEM_LOAD) data = '0;

        n_div[0].valid            = r_a_valid;
        n_div[0].res.dest_index   = writes ? rd : 5'd0;
        n_div[0].res.write_enable = we;
        n_div[0].res.write_data   = data;
        n_div[0].res.mem_kind     = kind;
        n_div[0].res.mem_size     = size;
        n_div[0].res.mem_address  = addr;
        n_div[0].res.store_value  = sdata;
        n_div[0].res.next_pc      = npc;
        n_div[0].res.pc_redirect  = taken;
        n_div[0].res.status       = status;
        n_div[0].is_div           = is_div;
        n_div[0].want_rem         = (f3 == rde_pkg::F3_REM);
        n_div[0].neg_q            = a[W-1] ^ b[W-1];
        n_div[0].neg_r            = a[W-1];
        n_div[0].rem              = '0;
        n_div[0].quo              = a[W-1] ? -a : a;
        n_div[0].divisor          = b[W-1] ? -b : b;
    end

    // ---------------- divider stages: one restoring step each ----------------
    genvar k;
    generate
        for (k = 0; k < rde_pkg::DIV_STAGES; k++) begin : g_div
            always_comb begin
                logic [W:0] rsh;
                logic       bit_q;
                n_div[k+1] = r_div[k];
                rsh   = {r_div[k].rem, r_div[k].quo[W-1]};
                bit_q = rsh >= {1'b0, r_div[k].divisor};
                if (bit_q) rsh = rsh - {1'b0, r_div[k].divisor};
                n_div[k+1].rem = rsh[W-1:0];
                n_div[k+1].quo = {r_div[k].quo[W-2:0], bit_q};
            end
        end
        for (k = 0; k < DIV_STAGES_P1; k++) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_div[k].valid <= 1'b0;
                end else if (w_adv) begin
                    r_div[k].valid <= n_div[k].valid;
                end
                if (w_adv) begin
                    r_div[k].res      <= n_div[k].res;
                    r_div[k].is_div   <= n_div[k].is_div;
                    r_div[k].want_rem <= n_div[k].want_rem;
                    r_div[k].neg_q    <= n_div[k].neg_q;
                    r_div[k].neg_r    <= n_div[k].neg_r;
                    r_div[k].rem      <= n_div[k].rem;
                    r_div[k].quo      <= n_div[k].quo;
                    r_div[k].divisor  <= n_div[k].divisor;
                end
            end
        end
    endgenerate

    // ---------------- output register: sign fix-up of div/rem ----------------
    rde_pkg::t_div  w_last;
    rde_pkg::t_res  n_out, r_out;
    logic           r_out_valid;
    logic [W-1:0]   w_q, w_r;

    assign w_last = r_div[DIV_STAGES_P1-1];
    assign w_q    = w_last.neg_q ? -w_last.quo : w_last.quo;
    assign w_r    = w_last.neg_r ? -w_last.rem : w_last.rem;

    always_comb begin
        n_out = w_last.res;
        if (w_last.is_div && w_last.res.write_enable) begin
            n_out.write_data = w_last.want_rem ? w_r : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_last.valid;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.dest_index   = r_out.dest_index;
    assign o_out.write_enable = r_out.write_enable;
    assign o_out.write_data   = r_out.write_data;
    assign o_out.mem_kind     = r_out.mem_kind;
    assign o_out.mem_size     = r_out.mem_size;
    assign o_out.mem_address  = r_out.mem_address;
    assign o_out.store_value  = r_out.store_value;
    assign o_out.next_pc      = r_out.next_pc;
    assign o_out.pc_redirect  = r_out.pc_redirect;
    assign o_out.status       = r_out.status;

    // ---------------- assertions ----------------
    `RDE_ASSERT_NOW(a_we_not_x0, i_clk, i_rst_n, o_out.valid && o_out.write_enable,
        o_out.dest_index != 5'd0 && o_out.status == rde_pkg::STATUS_OK)
    `RDE_ASSERT_NOW(a_halt_quiet, i_clk, i_rst_n,
        o_out.valid && o_out.status == rde_pkg::STATUS_HALT,
        !o_out.write_enable && !o_out.pc_redirect && o_out.mem_kind == rde_pkg::MEM_NONE)
    `RDE_ASSERT_NOW(a_no_mem_addr, i_clk, i_rst_n,
        o_out.valid && o_out.mem_kind == rde_pkg::MEM_NONE,
        o_out.mem_address == '0 && o_out.store_value == '0)
    `RDE_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, w_last.valid && !w_adv,
        r_div[DIV_STAGES_P1-1].valid)

endmodule

@@ tb/rde_tb_if.sv @@
`timescale 1ns / 1ps
// Testbench package: the type of one instruction word offered to the block.
// Depends on rde_pkg; the channels themselves come from rtl/core/rde_if.sv.
package rde_tb_pkg;

    // one instruction word offered to the block
    typedef struct packed {
        logic [rde_pkg::XLEN-1:0] instr_word;
        logic [rde_pkg::XLEN-1:0] pc_value;
        logic [rde_pkg::XLEN-1:0] src1_value;
        logic [rde_pkg::XLEN-1:0] src2_value;
    } t_instr;
endpackage

@@ tb/riscv_decode_execute_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of riscv_decode_execute: random and directed RV32IM words.
// Depends on rde_pkg, rde_if.sv, the RTL and tb/rde_tb_if.sv.
module riscv_decode_execute_tb;

    logic i_clk;
    logic i_rst_n;

    rde_in_if  in_ch ();
    rde_out_if out_ch ();

    riscv_decode_execute dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    rde_tb_pkg::t_instr pending_words[$];
    rde_pkg::t_res      expected_results[$];
    int     mismatch_count = 0;
    int     sent_count = 0;
    bit     hold_send = 0;   // sender pause until the pipe drains
    bit     in_quiet = 0;    // stretch without idling on either side
    int     rand_items = 700;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor: one result per instruction word
    // ---------------------------------------------------------------
    function automatic logic [31:0] sign_ext(logic [31:0] v, int bits);
        logic [31:0] m;
        m = 32'd1 << (bits - 1);
        v = v & ((m << 1) - 1);
        return (v ^ m) - m;
    endfunction

    function automatic logic [31:0] abs_val(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] signed_divrem(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] q, r;
        if (a == rde_pkg::SIGN_BIT && b == 32'hFFFF_FFFF)
            return want_rem ? 32'd0 : rde_pkg::SIGN_BIT;
        q = abs_val(a) / abs_val(b);
        r = abs_val(a) % abs_val(b);
        if (a[31] ^ b[31]) q = -q;
        if (a[31]) r = -r;
        return want_rem ? r : q;
    endfunction

    function automatic rde_pkg::t_res execute_instr(rde_tb_pkg::t_instr it);
        rde_pkg::t_res r;
        logic [31:0] w, pc, a, b, imm_i, imm_s, imm_b, imm_j, data, npc;
        logic [6:0]  opc, f7;
        logic [4:0]  rd, sh;
        logic [2:0]  f3;
        logic [1:0]  kind, size, stat;
        logic [31:0] addr, sdata;
        bit          writes, illegal, taken, cond;
        w = it.instr_word; pc = it.pc_value; a = it.src1_value; b = it.src2_value;
        opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25]; sh = b[4:0];
        imm_i = sign_ext(w >> 20, 12);
        imm_s = sign_ext(32'({f7, rd}), 12);
        imm_b = sign_ext(32'({w[31], w[7], w[30:25], w[11:8], 1'b0}), 13);
        imm_j = sign_ext(32'({w[31], w[19:12], w[20], w[30:21], 1'b0}), 21);
        data = 0; kind = rde_pkg::MEM_NONE; size = rde_pkg::SIZE_BYTE; addr = 0; sdata = 0;
        npc = pc + 32'd4; taken = 0; stat = rde_pkg::STATUS_OK;
        writes = 0; illegal = 0; cond = 0;
        if (w == 0) begin
            stat = rde_pkg::STATUS_HALT; npc = pc;
        end else begin
            case (opc)
                rde_pkg::OPC_REG: begin
                    writes = 1;
                    if (f7 == rde_pkg::F7_BASE) begin
                        case (f3)
                            rde_pkg::F3_ADD: data = a + b;
                            rde_pkg::F3_SLL: data = a << sh;
                            rde_pkg::F3_SLT: data = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            rde_pkg::F3_XOR: data = a ^ b;
                            rde_pkg::F3_SR:  data = a >> sh;
                            rde_pkg::F3_OR:  data = a | b;
                            rde_pkg::F3_AND: data = a & b;
                            default: illegal = 1;
                        endcase
                    end else if (f7 == rde_pkg::F7_ALT) begin
                        if (f3 == rde_pkg::F3_ADD) data = a - b;
                        else if (f3 == rde_pkg::F3_SR) data = $signed(a) >>> sh;
                        else illegal = 1;
                    end else if (f7 == rde_pkg::F7_MULD) begin
                        if (f3 == rde_pkg::F3_MUL) data = a * b;
                        else if (f3 == rde_pkg::F3_DIV || f3 == rde_pkg::F3_REM) begin
                            if (b == 0) stat = rde_pkg::STATUS_DIVZERO;
                            else data = signed_divrem(a, b, f3 == rde_pkg::F3_REM);
                        end else illegal = 1;
                    end else illegal = 1;
                end
                rde_pkg::OPC_IMM: begin
                    writes = 1;
                    if (f3 == rde_pkg::F3_ADD) data = a + imm_i;
                    else if (f3 == rde_pkg::F3_AND) data = a & imm_i;
                    else if (f3 == rde_pkg::F3_OR) data = a | imm_i;
                    else illegal = 1;
                end
                rde_pkg::OPC_LOAD: begin
                    writes = 1;
                    if (f3 <= rde_pkg::F3_SIZE_MAX) begin
                        kind = rde_pkg::MEM_LOAD; size = f3[1:0]; addr = a + imm_i;
                    end else illegal = 1;
                end
                rde_pkg::OPC_JALR: begin
                    writes = 1;
                    if (f3 == rde_pkg::F3_JALR) begin
                        data = pc + 32'd4; npc = (a + imm_i) & ~32'd1; taken = 1;
                    end else illegal = 1;
                end
                rde_pkg::OPC_STORE: begin
                    if (f3 <= rde_pkg::F3_SIZE_MAX) begin
                        kind = rde_pkg::MEM_STORE; size = f3[1:0]; addr = a + imm_s; sdata = b;
                    end else illegal = 1;
                end
                rde_pkg::OPC_BRANCH: begin
                    case (f3)
                        rde_pkg::F3_BEQ: cond = (a == b);
                        rde_pkg::F3_BNE: cond = (a != b);
                        rde_pkg::F3_BLT: cond = $signed(a) < $signed(b);
                        rde_pkg::F3_BGE: cond = !($signed(a) < $signed(b));
                        default: illegal = 1;
                    endcase
                    if (cond) begin
                        npc = pc + imm_b; taken = 1;
                    end
                end
                rde_pkg::OPC_AUIPC: begin
                    writes = 1; data = pc + {w[31:12], 12'd0};
                end
                rde_pkg::OPC_LUI: begin
                    writes = 1; data = {w[31:12], 12'd0};
                end
                rde_pkg::OPC_JAL: begin
                    writes = 1; data = pc + 32'd4; npc = pc + imm_j; taken = 1;
                end
                default: illegal = 1;
            endcase
        end
        if (illegal) begin
            writes = 0; kind = rde_pkg::MEM_NONE; size = rde_pkg::SIZE_BYTE; addr = 0;
            sdata = 0; npc = pc; taken = 0; stat = rde_pkg::STATUS_ILLEGAL;
        end
        r.dest_index   = writes ? rd : 5'd0;
        r.write_enable = writes && rd != 5'd0 && stat == rde_pkg::STATUS_OK;
        r.write_data   = (r.write_enable && kind != rde_pkg::MEM_LOAD) ? data : 32'd0;
        r.mem_kind     = kind;
        r.mem_size     = size;
        r.mem_address  = addr;
        r.store_value  = sdata;
        r.next_pc      = npc;
        r.pc_redirect  = taken;
        r.status       = stat;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return rde_pkg::SIGN_BIT;
            3: return 32'h7FFF_FFFF;
            4: return 32'd1;
            5: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // well-formed word of a random listed operation with random fields
    function automatic logic [31:0] legal_word();
        logic [31:0] w;
        logic [2:0]  f3;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                f3 = 3'($urandom);
                // funct3 3 is the one gap in the base register group
                w[31:25] = rde_pkg::F7_BASE; w[14:12] = (f3 == 3'd3) ? rde_pkg::F3_ADD : f3;
                w[6:0] = rde_pkg::OPC_REG;
            end
            1: begin
                w[31:25] = rde_pkg::F7_ALT;
                w[14:12] = $urandom_range(0, 1) ? rde_pkg::F3_ADD : rde_pkg::F3_SR;
                w[6:0] = rde_pkg::OPC_REG;
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: w[14:12] = rde_pkg::F3_MUL;
                    1: w[14:12] = rde_pkg::F3_DIV;
                    default: w[14:12] = rde_pkg::F3_REM;
                endcase
                w[31:25] = rde_pkg::F7_MULD; w[6:0] = rde_pkg::OPC_REG;
            end
            3: begin
                case ($urandom_range(0, 2))
                    0: w[14:12] = rde_pkg::F3_ADD;
                    1: w[14:12] = rde_pkg::F3_OR;
                    default: w[14:12] = rde_pkg::F3_AND;
                endcase
                w[6:0] = rde_pkg::OPC_IMM;
            end
            4: begin w[14:12] = 3'($urandom_range(0, 2)); w[6:0] = rde_pkg::OPC_LOAD; end
            5: begin w[14:12] = rde_pkg::F3_JALR; w[6:0] = rde_pkg::OPC_JALR; end
            6: begin w[14:12] = 3'($urandom_range(0, 2)); w[6:0] = rde_pkg::OPC_STORE; end
            7: begin
                case ($urandom_range(0, 3))
                    0: w[14:12] = rde_pkg::F3_BEQ;
                    1: w[14:12] = rde_pkg::F3_BNE;
                    2: w[14:12] = rde_pkg::F3_BLT;
                    default: w[14:12] = rde_pkg::F3_BGE;
                endcase
                w[6:0] = rde_pkg::OPC_BRANCH;
            end
            8: w[6:0] = $urandom_range(0, 1) ? rde_pkg::OPC_AUIPC : rde_pkg::OPC_LUI;
            default: w[6:0] = rde_pkg::OPC_JAL;
        endcase
        return w;
    endfunction

    task automatic queue_word(logic [31:0] w, logic [31:0] pc, logic [31:0] a, logic [31:0] b);
        rde_tb_pkg::t_instr it;
        it.instr_word = w; it.pc_value = pc; it.src1_value = a; it.src2_value = b;
        pending_words.push_back(it);
    endtask

    function automatic logic [31:0] r_word(logic [6:0] f7, logic [2:0] f3);
        return {f7, 5'd2, 5'd1, f3, 5'd3, rde_pkg::OPC_REG};
    endfunction

    initial begin
        int        i;
        logic [31:0] w, a, b;
        // directed: extremes, special cases and a selection of ops
        queue_word(32'd0, 32'h0000_1000, 32'h1, 32'h2);                        // halt
        queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // illegal
        queue_word(r_word(rde_pkg::F7_MULD, rde_pkg::F3_DIV), 32'h100,
                   rde_pkg::SIGN_BIT, 32'hFFFF_FFFF);                          // div ovf
        queue_word(r_word(rde_pkg::F7_MULD, rde_pkg::F3_REM), 32'h104,
                   rde_pkg::SIGN_BIT, 32'hFFFF_FFFF);                          // rem ovf
        queue_word(r_word(rde_pkg::F7_MULD, rde_pkg::F3_DIV), 32'h108, 32'd7, 32'd0); // div 0
        queue_word(r_word(rde_pkg::F7_MULD, rde_pkg::F3_REM), 32'h10C, -32'sd7, 32'd2);
        queue_word(r_word(rde_pkg::F7_ALT, rde_pkg::F3_SR), 32'h110,
                   rde_pkg::SIGN_BIT, 32'hFFFF_FFE3);                          // sra masked
        queue_word(r_word(rde_pkg::F7_BASE, rde_pkg::F3_SR), 32'h114,
                   rde_pkg::SIGN_BIT, 32'd33);                                 // srl
        queue_word(r_word(rde_pkg::F7_BASE, rde_pkg::F3_SLL), 32'h118, 32'h1, 32'd31);
        queue_word(r_word(rde_pkg::F7_BASE, rde_pkg::F3_SLT), 32'h11C,
                   rde_pkg::SIGN_BIT, 32'd1);                                  // slt
        queue_word(r_word(rde_pkg::F7_BASE, 3'd3), 32'h120, 32'd1, 32'd1);      // funct3 gap
        queue_word({12'hFFF, 5'd1, rde_pkg::F3_JALR, 5'd5, rde_pkg::OPC_JALR},
                   32'hFFFF_FFF0, 32'd4, 0);                                   // jalr bit0
        queue_word({12'h001, 5'd1, 3'd1, 5'd5, rde_pkg::OPC_JALR}, 32'h200, 32'd4, 0);
        queue_word({12'h001, 5'd1, 3'd3, 5'd5, rde_pkg::OPC_LOAD}, 32'h204, 32'd4, 0); // ld
        queue_word({7'h7F, 5'd2, 5'd1, 3'd3, 5'h1F, rde_pkg::OPC_STORE}, 32'h208, 1, 2); // sd
        queue_word({7'h40, 5'd2, 5'd1, rde_pkg::F3_BEQ, 5'h00, rde_pkg::OPC_BRANCH},
                   32'h20C, 5, 5);                                             // beq taken
        queue_word({7'h40, 5'd2, 5'd1, rde_pkg::F3_BEQ, 5'h00, rde_pkg::OPC_BRANCH},
                   32'h210, 5, 6);                                             // not taken
        queue_word({7'h00, 5'd2, 5'd1, 3'd6, 5'h08, rde_pkg::OPC_BRANCH}, 32'h214, 5, 6);
        queue_word({12'h001, 5'd1, 3'd1, 5'd5, rde_pkg::OPC_IMM}, 32'h218, 32'd4, 0); // slli
        queue_word({20'hFFFFF, 5'd0, rde_pkg::OPC_LUI}, 32'h21C, 0, 0);         // rd zero
        queue_word({20'h80000, 5'd9, rde_pkg::OPC_AUIPC}, 32'hFFFF_F000, 0, 0);
        queue_word({20'hFFFFF, 5'd1, rde_pkg::OPC_JAL}, 32'h0, 0, 0);
        queue_word({7'h5A, 5'd1, 5'd1, 3'd0, 5'd1, 7'h7B}, 32'h300, 0, 0);       // bad opcode
        for (i = 0; i < rand_items; i++) begin
            w = ($urandom_range(0, 99) < 85) ? legal_word() : $urandom;
            if ($urandom_range(0, 99) == 0) w = 32'd0;
            a = edge_value();
            b = edge_value();
            // equal operands make branch-equal taken often enough
            if ($urandom_range(0, 7) == 0) b = a;
            queue_word(w, $urandom, a, b);
        end
    end

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.instr_word <= '0;
            in_ch.pc_value   <= '0;
            in_ch.src1_value <= '0;
            in_ch.src2_value <= '0;
        end else begin
            bit fire;
            fire = in_ch.valid && in_ch.ready;
            if (fire) begin
                expected_results.push_back(execute_instr(pending_words.pop_front()));
                sent_count++;
            end
            if (in_ch.valid && !fire) begin
                // hold the current word
            end else if (pending_words.size() != 0 && !hold_send &&
                         (in_quiet || $urandom_range(0, 99) >= 35)) begin
                in_ch.valid      <= 1'b1;
                in_ch.instr_word <= pending_words[0].instr_word;
                in_ch.pc_value   <= pending_words[0].pc_value;
                in_ch.src1_value <= pending_words[0].src1_value;
                in_ch.src2_value <= pending_words[0].src2_value;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", out_ch.next_pc, 32'd0);
                end else begin
                    rde_pkg::t_res e;
                    e = expected_results.pop_front();
                    if (out_ch.dest_index !== e.dest_index)
                        report_mismatch("dest_index", 32'(out_ch.dest_index),
                                        32'(e.dest_index));
                    if (out_ch.write_enable !== e.write_enable)
                        report_mismatch("write_enable", 32'(out_ch.write_enable),
                                        32'(e.write_enable));
                    if (out_ch.write_data !== e.write_data)
                        report_mismatch("write_data", out_ch.write_data, e.write_data);
                    if (out_ch.mem_kind !== e.mem_kind)
                        report_mismatch("mem_kind", 32'(out_ch.mem_kind), 32'(e.mem_kind));
                    if (out_ch.mem_size !== e.mem_size)
                        report_mismatch("mem_size", 32'(out_ch.mem_size), 32'(e.mem_size));
                    if (out_ch.mem_address !== e.mem_address)
                        report_mismatch("mem_address", out_ch.mem_address, e.mem_address);
                    if (out_ch.store_value !== e.store_value)
                        report_mismatch("store_value", out_ch.store_value, e.store_value);
                    if (out_ch.next_pc !== e.next_pc)
                        report_mismatch("next_pc", out_ch.next_pc, e.next_pc);
                    if (out_ch.pc_redirect !== e.pc_redirect)
                        report_mismatch("pc_redirect", 32'(out_ch.pc_redirect),
                                        32'(e.pc_redirect));
                    if (out_ch.status !== e.status)
                        report_mismatch("status", 32'(out_ch.status), 32'(e.status));
                end
            end
            out_ch.ready <= in_quiet || $urandom_range(0, 99) >= 35;
        end
    end

    // ---------------------------------------------------------------
    // Run control
    // ---------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // drain once mid-run: sender holds until every result is back
        wait (sent_count >= 200);
        @(posedge i_clk);
        hold_send <= 1'b1;
        wait (!(in_ch.valid) && expected_results.size() == 0);
        @(posedge i_clk);
        hold_send <= 1'b0;
        // stretch with both sides always busy
        wait (sent_count >= 350);
        @(posedge i_clk);
        in_quiet <= 1'b1;
        wait (sent_count >= 500);
        @(posedge i_clk);
        in_quiet <= 1'b0;
        wait (pending_words.size() == 0 && !in_ch.valid);
        wait (expected_results.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
